### src/bitmap_page_frame_allocator_defines.svh
// Assertion macros used by the allocator controller RTL.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Clocked check, quiet while reset is held.
`define BPFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BPFA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/bpfa_pkg.sv
// Shared constants, codes and controller/datapath structs of the page allocator.
package bpfa_pkg;

    localparam int BPFA_NUM_PAGES = 4096;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_RESERVE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [9:0] TRACKED_RESET = 10'd512;
    localparam logic [7:0] BYTE_ALL_TAKEN = 8'hff;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       clr_step;
        logic       scan_start;
        logic       scan_step;
        logic       mark_start;
        logic       mark_from_hit;
        logic       mark_step;
        logic       res_load;
        logic [1:0] res_status;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic is_bad;
        logic cnt_zero;
        logic lim_zero;
        logic range_bad;
        logic scan_hit;
        logic scan_end;
        logic mark_last;
    } t_sts;

endpackage

### src/bpfa_datapath.sv
// Bitmap store, scan/mark engines, config register and result register.
module bpfa_datapath
    import bpfa_pkg::*;
#(
    parameter int NUM_PAGES = BPFA_NUM_PAGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    output t_sts        o_sts,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    input  logic [1:0]  i_command,
    input  logic [11:0] i_base_page,
    input  logic [12:0] i_page_count,
    output logic [1:0]  o_status,
    output logic [11:0] o_found_page
);

    localparam int NUM_BYTES = NUM_PAGES / 8;
    localparam int AW  = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
    localparam int LBW = $clog2(NUM_BYTES + 1);
    localparam int PGW = AW + 3;
    localparam int SW  = (((LBW + 3) > 14) ? (LBW + 3) : 14) + 1;

    logic [7:0]     mem [NUM_BYTES];
    logic [7:0]     r_q;

    logic [9:0]     r_tracked;
    logic [1:0]     r_cmd;
    logic [11:0]    r_base;
    logic [12:0]    r_count;

    logic [LBW-1:0] r_clr_addr;
    logic [LBW-1:0] r_rd_addr;
    logic           r_pend;
    logic [AW-1:0]  r_pidx;
    logic [12:0]    r_run;
    logic [PGW-1:0] r_cur_start;
    logic [PGW-1:0] r_hit_start;
    logic [11:0]    r_found;

    logic [PGW-1:0] r_ms;
    logic [SW-1:0]  r_me;
    logic [AW-1:0]  r_mlast;
    logic [AW-1:0]  r_mk_addr;
    logic           r_mpend;
    logic [AW-1:0]  r_midx;
    logic           r_mval;

    logic [1:0]     r_res_status;
    logic [11:0]    r_res_found;

    logic [LBW-1:0] lim_bytes;
    logic [SW-1:0]  lim_pages;
    logic           scan_issue;
    logic           scan_last;
    logic [12:0]    v_run;
    logic [PGW-1:0] v_start;
    logic           v_hit;
    logic [PGW-1:0] v_hs;
    logic [7:0]     mk_mask;
    logic [7:0]     mk_data;
    logic           mk_we;
    logic [PGW-1:0] ms_sel;
    logic [SW-1:0]  me_sel;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;

    // tracked size clipped to the store
    always_comb begin
        if (SW'(r_tracked) > SW'(NUM_BYTES)) begin
            lim_bytes = LBW'(NUM_BYTES);
        end else begin
            lim_bytes = LBW'(r_tracked);
        end
        lim_pages = SW'({lim_bytes, 3'b000});
    end

    assign scan_issue = r_rd_addr < lim_bytes;
    assign scan_last  = LBW'(r_pidx) == (lim_bytes - LBW'(1));

    // first-fit run tracking over one byte, page 8i at the MSB
    always_comb begin
        v_run   = r_run;
        v_start = r_cur_start;
        v_hit   = 1'b0;
        v_hs    = r_cur_start;
        for (int k = 0; k < 8; k++) begin
            if (!v_hit) begin
                if (r_q[7 - k]) begin
                    v_run = '0;
                end else begin
                    if (v_run == '0) begin
                        v_start = {r_pidx, 3'(k)};
                    end
                    v_run = v_run + 13'd1;
                    if (v_run == r_count) begin
                        v_hit = 1'b1;
                        v_hs  = v_start;
                    end
                end
            end
        end
    end

    // run mask for the byte coming back during marking
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            mk_mask[7 - k] = (SW'({r_midx, 3'(k)}) >= SW'(r_ms)) &&
                             (SW'({r_midx, 3'(k)}) < r_me);
        end
        mk_data = r_mval ? (r_q | mk_mask) : (r_q & ~mk_mask);
        mk_we   = i_ctl.mark_step && r_mpend;
    end

    assign ms_sel = i_ctl.mark_from_hit ? r_hit_start : PGW'(r_base);
    assign me_sel = SW'(ms_sel) + SW'(r_count);

    assign rd_en   = i_ctl.scan_step || i_ctl.mark_step;
    assign rd_addr = i_ctl.mark_step ? r_mk_addr : r_rd_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step) begin
            mem[r_clr_addr[AW-1:0]] <= BYTE_ALL_TAKEN;
        end else if (mk_we) begin
            mem[r_midx] <= mk_data;
        end
        if (rd_en) begin
            r_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked  <= TRACKED_RESET;
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
            r_mpend    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tracked <= i_cfg_wdata;
            end
            if (i_ctl.clr_step) begin
                r_clr_addr <= r_clr_addr + LBW'(1);
            end
            if (i_ctl.scan_start) begin
                r_pend <= 1'b0;
            end else if (i_ctl.scan_step) begin
                r_pend <= scan_issue;
            end
            if (i_ctl.mark_start) begin
                r_mpend <= 1'b0;
            end else if (i_ctl.mark_step) begin
                r_mpend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_command;
            r_base  <= i_base_page;
            r_count <= i_page_count;
            r_found <= '0;
            r_mval  <= (i_command == CMD_ALLOC) || (i_command == CMD_RESERVE);
        end
        if (i_ctl.scan_start) begin
            r_rd_addr <= '0;
            r_run     <= '0;
        end else if (i_ctl.scan_step) begin
            if (scan_issue) begin
                r_rd_addr <= r_rd_addr + LBW'(1);
                r_pidx    <= r_rd_addr[AW-1:0];
            end
            if (r_pend) begin
                r_run       <= v_run;
                r_cur_start <= v_start;
                if (v_hit) begin
                    r_hit_start <= v_hs;
                    r_found     <= 12'(v_hs);
                end
            end
        end
        if (i_ctl.mark_start) begin
            r_ms      <= ms_sel;
            r_me      <= me_sel;
            r_mlast   <= AW'((me_sel - SW'(1)) >> 3);
            r_mk_addr <= ms_sel[PGW-1:3];
        end else if (i_ctl.mark_step) begin
            r_mk_addr <= r_mk_addr + AW'(1);
            r_midx    <= r_mk_addr;
        end
        if (i_ctl.res_load) begin
            r_res_status <= i_ctl.res_status;
            r_res_found  <= r_found;
        end
    end

    always_comb begin
        o_sts.clr_last  = r_clr_addr == LBW'(NUM_BYTES - 1);
        o_sts.is_alloc  = r_cmd == CMD_ALLOC;
        o_sts.is_bad    = (r_cmd != CMD_ALLOC) && (r_cmd != CMD_FREE) &&
                          (r_cmd != CMD_RESERVE);
        o_sts.cnt_zero  = r_count == '0;
        o_sts.lim_zero  = lim_bytes == '0;
        o_sts.range_bad = (SW'(r_base) + SW'(r_count)) > lim_pages;
        o_sts.scan_hit  = r_pend && v_hit;
        o_sts.scan_end  = r_pend && scan_last && !v_hit;
        o_sts.mark_last = r_mpend && (r_midx == r_mlast);
    end

    assign o_status     = r_res_status;
    assign o_found_page = r_res_found;

endmodule

### src/bpfa_ctrl.sv
// Command sequencer: clearing pass, decode, scan, mark and result handoff.
`include "bitmap_page_frame_allocator_defines.svh"

module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DECODE = 6'b000100,
        S_SCAN   = 6'b001000,
        S_MARK   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       r_out_vld, n_out_vld;
    logic       r_hit_d;

    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_out_vld = r_out_vld;
        o_ctl     = '0;
        o_ctl.res_status = r_status;
        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_alloc) begin
                    if (i_sts.cnt_zero || i_sts.lim_zero) begin
                        n_status = ST_NOMEM;
                        n_state  = S_DONE;
                    end else begin
                        o_ctl.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end else if (i_sts.is_bad) begin
                    n_status = ST_RANGE;
                    n_state  = S_DONE;
                end else if (i_sts.cnt_zero) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else if (i_sts.range_bad) begin
                    n_status = ST_RANGE;
                    n_state  = S_DONE;
                end else begin
                    o_ctl.mark_start = 1'b1;
                    n_state          = S_MARK;
                end
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = S_MARK;
                end else if (i_sts.scan_end) begin
                    n_status = ST_NOMEM;
                    n_state  = S_DONE;
                end
            end
            S_MARK: begin
                if (r_hit_d) begin
                    o_ctl.mark_start    = 1'b1;
                    o_ctl.mark_from_hit = 1'b1;
                end else begin
                    o_ctl.mark_step = 1'b1;
                    if (i_sts.mark_last) begin
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    o_ctl.res_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // mark setup is launched the cycle after a hit, once the hit base is stored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_d <= 1'b0;
        end else begin
            r_hit_d <= (r_state == S_SCAN) && i_sts.scan_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        r_status <= n_status;
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_out_vld;

    `BPFA_ASSERT(a_res_from_done, $rose(r_out_vld) |-> $past(r_state == S_DONE), "result without finish")
    `BPFA_ASSERT(a_mark_to_done, (r_state == S_MARK && !r_hit_d && i_sts.mark_last) |=> r_state == S_DONE, "mark end lost")
    `BPFA_ASSERT(a_hold_result, (r_state == S_DONE && r_out_vld && !i_m_tready) |=> r_state == S_DONE, "result overwritten")
    `BPFA_ASSERT_ALWAYS(a_no_accept_clear, r_state == S_CLEAR |-> !o_s_tready, "accept during clear")

endmodule

### src/bitmap_page_frame_allocator.sv
// Bitmap first-fit page frame allocator, top level.
// Usage:
//  - Slave stream (i_s_*) carries one command item: allocate, free or reserve a run
//    of pages. Master stream (o_m_*) returns exactly one result item per command:
//    a status code and, for a successful allocate, the base page of the run.
//  - i_cfg_we/i_cfg_wdata set the number of tracked bitmap bytes (8 pages each);
//    write it only while the block is idle. Reset value is 512.
//  - Reset (synchronous, active low) starts a clearing pass that marks every page
//    allocated, one byte per cycle across the store's NUM_PAGES/8 bytes (512 at
//    the default size). o_s_tready stays low until the pass is done.
//  - Items are handled one at a time. Allocate walks the bitmap store one byte per
//    cycle (one read port) over up to the tracked bytes to find a run, then marks
//    the bytes spanned by the run. Free and reserve mark the bytes spanned. Each
//    command also passes through decode and result handoff. Rejected and
//    zero-length commands skip the scan and mark steps.
//  - A finished result sits in an output register; the next command is accepted
//    while it waits. If the receiver stalls, the following result is held back
//    until the register drains, and no further command is taken meanwhile.
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int NUM_PAGES = BPFA_NUM_PAGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [1:0] command, [13:2] base_page, [26:14] page_count
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [1:0] status, [13:2] found_page
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata
);

    t_ctl        ctl;
    t_sts        sts;
    logic [1:0]  status;
    logic [11:0] found_page;

    bpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    bpfa_datapath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_command    (i_s_tdata[1:0]),
        .i_base_page  (i_s_tdata[13:2]),
        .i_page_count (i_s_tdata[26:14]),
        .o_status     (status),
        .o_found_page (found_page)
    );

    // result fields packed low bit first, zero filled to 16 bits
    assign o_m_tdata = {2'b00, found_page, status};

endmodule
